// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the pair matcher checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ----- rtl/dbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// dbpm_pkg
// Types and constants for the dot-bracket pair matcher.
// ----------------------------------------------------------------------------
package dbpm_pkg;

   // Structure characters that occupy a position
   localparam logic [7:0] SYM_DOT          = 8'h2E;  // '.'
   localparam logic [7:0] SYM_OPEN_ROUND   = 8'h28;  // '('
   localparam logic [7:0] SYM_CLOSE_ROUND  = 8'h29;  // ')'
   localparam logic [7:0] SYM_OPEN_SQUARE  = 8'h5B;  // '['
   localparam logic [7:0] SYM_CLOSE_SQUARE = 8'h5D;  // ']'

   // Field widths
   localparam int SYMBOL_W   = 8;
   localparam int POS_OUT_W  = 10;
   localparam int INDEX_W    = 9;
   localparam int COUNT_W    = 10;
   localparam int ERR_W      = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   // Response tdata layout, low bit of each field
   localparam int OPEN_LSB  = 0;
   localparam int CLOSE_LSB = OPEN_LSB + POS_OUT_W;
   localparam int INDEX_LSB = CLOSE_LSB + POS_OUT_W;
   localparam int TOTAL_LSB = INDEX_LSB + INDEX_W;
   localparam int ERR_LSB   = TOTAL_LSB + COUNT_W;
   localparam int USED_W    = ERR_LSB + ERR_W;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 3'd0,
      ERR_ROUND    = 3'd1,
      ERR_SQUARE   = 3'd2,
      ERR_UNCLOSED = 3'd3,
      ERR_OVERFLOW = 3'd4,
      ERR_LONG     = 3'd5
   } err_type;

   // Stack commands from the top level: push, pop and clear
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stack_ctl_type;

   // Stack occupancy flags
   typedef struct packed {
      logic empty;
      logic single;
      logic full;
   } stack_stat_type;

endpackage

// ----- rtl/dot_bracket_pair_matcher_core.sv -----
// ----------------------------------------------------------------------------
// dot_bracket_pair_matcher_core
// Turns a dot-bracket structure string into a stream of base pairs.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one byte of the structure string per request; req_tlast
//   marks the final byte. Only . ( ) [ ] take a position, other bytes pass
//   without effect. Round and square openers go on two separate stacks.
//   rsp_* carries a response for each closer that forms a pair (rsp_tuser
//   set) and one response for the final byte (rsp_tlast set), which holds the
//   pair count and the error code; a pair closed by the final byte rides in
//   that same response. Errors are held and reported only at the end.
//   Each response is registered. Throughput is one request per cycle:
//   each stack keeps its top in a register and its RAM read port always
//   holds the entry below, so a pop never waits on a read. When rsp_tready
//   is low the response register holds and req_tready drops only while
//   that register is full and stalled.
//   Reset (synchronous) empties both stacks and clears counts and errors;
//   no clearing pass is needed. The final byte clears the same state.
// ----------------------------------------------------------------------------
module dot_bracket_pair_matcher_core #(
   parameter int MAX_LENGTH  = 1024,
   parameter int STACK_DEPTH = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dbpm_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] symbol
   input  logic                            req_tlast,   // last
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [9:0] open_pos, [19:10] close_pos, [28:20] pair_index,
   // [38:29] total_pairs, [41:39] error_code, [47:42] zero
   output logic [dbpm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,   // pair_valid
   output logic                            rsp_tlast    // done_res
);

   localparam int PCW = $clog2(MAX_LENGTH + 1);
   localparam int PW  = $clog2(MAX_LENGTH);

   logic [PCW-1:0]                    pos_ff, pos_in;
   logic [dbpm_pkg::COUNT_W-1:0]      pairs_ff, pairs_in;
   dbpm_pkg::err_type                 err_ff, err_step, err_final, err_in;

   logic                              rsp_valid_ff;
   logic [dbpm_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                              rsp_user_ff, rsp_last_ff;

   logic                              accept, counted, live, too_long, step;
   logic                              is_open_r, is_close_r, is_open_s, is_close_s;
   logic                              paired, emit;
   logic [PW-1:0]                     cur_pos, opened;
   logic [31:0]                       opened_wide, closed_wide;
   logic                              r_busy_after, s_busy_after;

   dbpm_pkg::stack_ctl_type           r_ctl, s_ctl;
   dbpm_pkg::stack_stat_type          r_stat, s_stat;
   logic [PW-1:0]                     r_tos, s_tos;

   // Handshake: output register parts the two sides
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Symbol decode
   assign is_open_r  = (req_tdata == dbpm_pkg::SYM_OPEN_ROUND);
   assign is_close_r = (req_tdata == dbpm_pkg::SYM_CLOSE_ROUND);
   assign is_open_s  = (req_tdata == dbpm_pkg::SYM_OPEN_SQUARE);
   assign is_close_s = (req_tdata == dbpm_pkg::SYM_CLOSE_SQUARE);
   assign counted    = is_open_r || is_close_r || is_open_s || is_close_s ||
                       (req_tdata == dbpm_pkg::SYM_DOT);

   // A counted byte only acts while no error is held
   assign live     = accept && counted && (err_ff == dbpm_pkg::ERR_NONE);
   assign too_long = (pos_ff >= PCW'(MAX_LENGTH));
   assign step     = live && !too_long;
   assign cur_pos  = pos_ff[PW-1:0];

   // Stack commands
   assign r_ctl.push  = step && is_open_r && !r_stat.full;
   assign r_ctl.pop   = step && is_close_r && !r_stat.empty;
   assign r_ctl.clear = accept && req_tlast;
   assign s_ctl.push  = step && is_open_s && !s_stat.full;
   assign s_ctl.pop   = step && is_close_s && !s_stat.empty;
   assign s_ctl.clear = accept && req_tlast;

   dbpm_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .PW          (PW)
   ) u_round_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (r_ctl),
      .push_data (cur_pos),
      .tos       (r_tos),
      .stat      (r_stat)
   );

   dbpm_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .PW          (PW)
   ) u_square_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (s_ctl),
      .push_data (cur_pos),
      .tos       (s_tos),
      .stat      (s_stat)
   );

   // Pair formation
   assign paired = r_ctl.pop || s_ctl.pop;
   assign opened = r_ctl.pop ? r_tos : s_tos;
   assign emit   = accept && (paired || req_tlast);

   // Error update for this byte
   always_comb begin
      err_step = err_ff;
      if (live) begin
         if (too_long) begin
            err_step = dbpm_pkg::ERR_LONG;
         end else if ((is_open_r && r_stat.full) || (is_open_s && s_stat.full)) begin
            err_step = dbpm_pkg::ERR_OVERFLOW;
         end else if (is_close_r && r_stat.empty) begin
            err_step = dbpm_pkg::ERR_ROUND;
         end else if (is_close_s && s_stat.empty) begin
            err_step = dbpm_pkg::ERR_SQUARE;
         end
      end
   end

   // Openers still pending once the final byte is handled
   assign r_busy_after = r_ctl.push || (!r_stat.empty && !(r_ctl.pop && r_stat.single));
   assign s_busy_after = s_ctl.push || (!s_stat.empty && !(s_ctl.pop && s_stat.single));

   always_comb begin
      err_final = err_step;
      if (req_tlast && (err_step == dbpm_pkg::ERR_NONE) && (r_busy_after || s_busy_after)) begin
         err_final = dbpm_pkg::ERR_UNCLOSED;
      end
   end

   // Counter next values; final byte clears everything
   always_comb begin
      pos_in   = pos_ff;
      pairs_in = pairs_ff;
      err_in   = err_ff;
      if (accept) begin
         if (step) begin
            pos_in = pos_ff + PCW'(1);
         end
         if (paired) begin
            pairs_in = pairs_ff + dbpm_pkg::COUNT_W'(1);
         end
         err_in = err_step;
         if (req_tlast) begin
            pos_in   = '0;
            pairs_in = '0;
            err_in   = dbpm_pkg::ERR_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         pairs_ff <= '0;
         err_ff   <= dbpm_pkg::ERR_NONE;
      end else begin
         pos_ff   <= pos_in;
         pairs_ff <= pairs_in;
         err_ff   <= err_in;
      end
   end

   // Response payload
   assign opened_wide = 32'(opened);
   assign closed_wide = 32'(cur_pos);

   always_comb begin
      rsp_data_in = '0;
      if (paired) begin
         rsp_data_in[dbpm_pkg::OPEN_LSB +: dbpm_pkg::POS_OUT_W] =
            opened_wide[dbpm_pkg::POS_OUT_W-1:0];
         rsp_data_in[dbpm_pkg::CLOSE_LSB +: dbpm_pkg::POS_OUT_W] =
            closed_wide[dbpm_pkg::POS_OUT_W-1:0];
         rsp_data_in[dbpm_pkg::INDEX_LSB +: dbpm_pkg::INDEX_W] =
            pairs_ff[dbpm_pkg::INDEX_W-1:0];
      end
      rsp_data_in[dbpm_pkg::TOTAL_LSB +: dbpm_pkg::COUNT_W] =
         paired ? (pairs_ff + dbpm_pkg::COUNT_W'(1)) : pairs_ff;
      if (req_tlast) begin
         rsp_data_in[dbpm_pkg::ERR_LSB +: dbpm_pkg::ERR_W] = err_final;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= paired;
         rsp_last_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/dbpm_ram.sv -----
// ----------------------------------------------------------------------------
// dbpm_ram
// Generic single-write, single-read RAM with registered, write-first read.
// ----------------------------------------------------------------------------
module dbpm_ram #(
   parameter  int WIDTH = 10,
   parameter  int DEPTH = 512,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, new data forwarded on an address collision
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dbpm_stack.sv -----
// ----------------------------------------------------------------------------
// dbpm_stack
// Position stack: top entry in a register, the rest in a RAM whose read port
// always holds the entry just below the top.
// ----------------------------------------------------------------------------
module dbpm_stack #(
   parameter int STACK_DEPTH = 512,
   parameter int PW          = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dbpm_pkg::stack_ctl_type ctl,
   input  logic [PW-1:0]           push_data,
   output logic [PW-1:0]           tos,
   output dbpm_pkg::stack_stat_type stat
);

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [DW-1:0] depth_ff, depth_in;
   logic [PW-1:0] tos_ff, tos_in;
   logic [PW-1:0] below;
   logic [DW-1:0] wr_addr_full, rd_addr_full;
   logic          wr_en;

   // Depth and top-of-stack next values; clear wins over a same-cycle op
   always_comb begin
      depth_in = depth_ff;
      tos_in   = tos_ff;
      if (ctl.push) begin
         depth_in = depth_ff + DW'(1);
         tos_in   = push_data;
      end else if (ctl.pop) begin
         depth_in = depth_ff - DW'(1);
         tos_in   = below;
      end
      if (ctl.clear) begin
         depth_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
   end

   // Spill old top on push; prefetch the entry under the new top
   assign wr_en        = ctl.push && (depth_ff != '0);
   assign wr_addr_full = depth_ff - DW'(1);
   assign rd_addr_full = depth_in - DW'(2);

   dbpm_ram #(
      .WIDTH (PW),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_full[AW-1:0]),
      .wr_data (tos_ff),
      .rd_addr (rd_addr_full[AW-1:0]),
      .rd_data (below)
   );

   assign tos         = tos_ff;
   assign stat.empty  = (depth_ff == '0);
   assign stat.single = (depth_ff == DW'(1));
   assign stat.full   = (depth_ff == DW'(STACK_DEPTH));

endmodule

// ----- rtl/dbpm_checker.sv -----
// ----------------------------------------------------------------------------
// dbpm_checker
// Port-level checks on the pair matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbpm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dbpm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);

   logic [dbpm_pkg::ERR_W-1:0]      err_code;
   logic                            no_pair_fields;
   logic                            err_known;
   logic                            rsp_stall;
   logic [dbpm_pkg::RSP_DATA_W+1:0] rsp_payload;

   assign err_code       = rsp_tdata[dbpm_pkg::ERR_LSB +: dbpm_pkg::ERR_W];
   assign no_pair_fields = (rsp_tdata[dbpm_pkg::TOTAL_LSB-1:0] == '0);
   assign err_known      = (err_code <= dbpm_pkg::ERR_LONG);
   assign rsp_stall      = rsp_tvalid && !rsp_tready;
   assign rsp_payload    = {rsp_tdata, rsp_tuser, rsp_tlast};

   // Stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_payload))

   // Request side is open whenever the response register is empty
   `ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // Every response that is not the final one carries a pair
   `ASSERT_IMPLIES(a_mid_is_pair, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tuser)

   // Errors are reported only in the final response
   `ASSERT_IMPLIES(a_err_at_end, clock, reset, rsp_tvalid && !rsp_tlast, err_code == dbpm_pkg::ERR_NONE)

   // A response without a pair has zeroed pair fields and a known error code
   `ASSERT_IMPLIES(a_done_fields, clock, reset, rsp_tvalid && !rsp_tuser, no_pair_fields && err_known)

endmodule

bind dot_bracket_pair_matcher_core dbpm_checker u_dbpm_checker (.*);

// ----- tb/tb_dot_bracket_pair_matcher_core.sv -----
// ----------------------------------------------------------------------------
// tb_dot_bracket_pair_matcher_core
// Self-checking bench for the dot-bracket pair matcher: structure strings go
// in one byte per request, and every response is compared field by field with
// a local prediction of the two bracket stacks, counts and sticky errors.
// ----------------------------------------------------------------------------
module tb_dot_bracket_pair_matcher_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_LENGTH   = 1024;
   localparam int          STACK_DEPTH  = 512;
   localparam int          SAW          = $clog2(STACK_DEPTH);
   localparam int unsigned RANDOM_ITEMS = 390;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          IDLE_PCT     = 10;

   // one response as the block should produce it
   typedef struct packed {
      logic                           pair_valid;
      logic [dbpm_pkg::POS_OUT_W-1:0] open_pos;
      logic [dbpm_pkg::POS_OUT_W-1:0] close_pos;
      logic [dbpm_pkg::INDEX_W-1:0]   pair_index;
      logic                           done;
      logic [dbpm_pkg::COUNT_W-1:0]   total_pairs;
      dbpm_pkg::err_type              error_code;
   } pair_result_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dbpm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [dbpm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;

   // predicted matcher state
   logic [10:0]                    position_count = '0;
   logic [dbpm_pkg::POS_OUT_W-1:0] round_opens [STACK_DEPTH];
   logic [dbpm_pkg::POS_OUT_W-1:0] square_opens[STACK_DEPTH];
   logic [9:0]                     round_depth    = '0;
   logic [9:0]                     square_depth   = '0;
   logic [dbpm_pkg::COUNT_W-1:0]   pairs_found    = '0;
   dbpm_pkg::err_type              held_error     = dbpm_pkg::ERR_NONE;

   pair_result_type expected_pairs[$];
   int unsigned     fail_count  = 0;
   int unsigned     item_count  = 0;
   int unsigned     cycle_count = 0;
   bit              steady      = 1'b0;   // no idling on either side while set

   dot_bracket_pair_matcher_core #(
      .MAX_LENGTH (MAX_LENGTH),
      .STACK_DEPTH(STACK_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: cycle limit reached, %0d responses outstanding",
                  $time, expected_pairs.size());
         $display("dot_bracket_pair_matcher_core regression: fail");
         $finish;
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   function automatic bit is_position(input logic [7:0] sym);
      return sym == dbpm_pkg::SYM_DOT || sym == dbpm_pkg::SYM_OPEN_ROUND ||
             sym == dbpm_pkg::SYM_CLOSE_ROUND || sym == dbpm_pkg::SYM_OPEN_SQUARE ||
             sym == dbpm_pkg::SYM_CLOSE_SQUARE;
   endfunction

   // advance the predicted state by one accepted request
   task automatic predict_pairs(input logic [7:0] sym, input logic is_last);
      pair_result_type                res;
      logic                           paired;
      logic [dbpm_pkg::POS_OUT_W-1:0] pos;
      logic [dbpm_pkg::POS_OUT_W-1:0] opened;
      logic [dbpm_pkg::INDEX_W-1:0]   index;
      paired = 1'b0;
      opened = '0;
      index  = '0;
      pos    = position_count[dbpm_pkg::POS_OUT_W-1:0];
      if (is_position(sym) && held_error == dbpm_pkg::ERR_NONE) begin
         if (position_count >= MAX_LENGTH) begin
            held_error = dbpm_pkg::ERR_LONG;
         end else begin
            position_count = position_count + 11'd1;
            case (sym)
               dbpm_pkg::SYM_OPEN_ROUND: begin
                  if (round_depth >= STACK_DEPTH) begin
                     held_error = dbpm_pkg::ERR_OVERFLOW;
                  end else begin
                     round_opens[round_depth[SAW-1:0]] = pos;
                     round_depth = round_depth + 10'd1;
                  end
               end
               dbpm_pkg::SYM_OPEN_SQUARE: begin
                  if (square_depth >= STACK_DEPTH) begin
                     held_error = dbpm_pkg::ERR_OVERFLOW;
                  end else begin
                     square_opens[square_depth[SAW-1:0]] = pos;
                     square_depth = square_depth + 10'd1;
                  end
               end
               dbpm_pkg::SYM_CLOSE_ROUND: begin
                  if (round_depth == 0) begin
                     held_error = dbpm_pkg::ERR_ROUND;
                  end else begin
                     round_depth = round_depth - 10'd1;
                     opened = round_opens[round_depth[SAW-1:0]];
                     paired = 1'b1;
                  end
               end
               dbpm_pkg::SYM_CLOSE_SQUARE: begin
                  if (square_depth == 0) begin
                     held_error = dbpm_pkg::ERR_SQUARE;
                  end else begin
                     square_depth = square_depth - 10'd1;
                     opened = square_opens[square_depth[SAW-1:0]];
                     paired = 1'b1;
                  end
               end
               default: ;
            endcase
            if (paired) begin
               index = pairs_found[dbpm_pkg::INDEX_W-1:0];
               pairs_found = pairs_found + dbpm_pkg::COUNT_W'(1);
            end
         end
      end
      if (is_last && held_error == dbpm_pkg::ERR_NONE &&
          (round_depth != 0 || square_depth != 0))
         held_error = dbpm_pkg::ERR_UNCLOSED;
      if (paired || is_last) begin
         res.pair_valid  = paired;
         res.open_pos    = paired ? opened : '0;
         res.close_pos   = paired ? pos : '0;
         res.pair_index  = index;
         res.done        = is_last;
         res.total_pairs = pairs_found;
         res.error_code  = is_last ? held_error : dbpm_pkg::ERR_NONE;
         expected_pairs.insert(expected_pairs.size(), res);
      end
      if (is_last) begin
         position_count = '0;
         round_depth    = '0;
         square_depth   = '0;
         pairs_found    = '0;
         held_error     = dbpm_pkg::ERR_NONE;
      end
   endtask

   // send one byte; idles at random first, leaves tvalid high on return
   task automatic send_symbol(input logic [7:0] sym, input logic is_last);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_pairs(sym, is_last);
      item_count++;
   endtask

   // whole string, last flag on the final byte
   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_symbol(text[i], i == text.len() - 1);
   endtask

   // hold off the sender until every predicted response has arrived
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pairs.size() != 0) @(posedge clock);
   endtask

   // response checker
   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_responses
      pair_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pairs.size() == 0) begin
            $display("%0t ns: response with none expected, expected nothing, actual %h/%b/%b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            fail_count++;
         end else begin
            want = expected_pairs.pop_front();
            check_field("pair_valid", want.pair_valid, rsp_tuser);
            check_field("open_pos", want.open_pos,
                        rsp_tdata[dbpm_pkg::OPEN_LSB +: dbpm_pkg::POS_OUT_W]);
            check_field("close_pos", want.close_pos,
                        rsp_tdata[dbpm_pkg::CLOSE_LSB +: dbpm_pkg::POS_OUT_W]);
            check_field("pair_index", want.pair_index,
                        rsp_tdata[dbpm_pkg::INDEX_LSB +: dbpm_pkg::INDEX_W]);
            check_field("done", want.done, rsp_tlast);
            check_field("total_pairs", want.total_pairs,
                        rsp_tdata[dbpm_pkg::TOTAL_LSB +: dbpm_pkg::COUNT_W]);
            check_field("error_code", want.error_code,
                        rsp_tdata[dbpm_pkg::ERR_LSB +: dbpm_pkg::ERR_W]);
            check_field("padding", 0, rsp_tdata[dbpm_pkg::RSP_DATA_W-1:dbpm_pkg::USED_W]);
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // plain pairs, crossed types, pair closed by the final byte
   task automatic test_basic_pairs();
      send_text(".");
      send_text("()");
      send_text("(&[)]");
   endtask

   // unmatched closers, errors holding until the end, unclosed openers
   task automatic test_error_codes();
      send_text(")(.");
      send_text("]");
      send_text("(()&");
      send_text("[");
   endtask

   // bytes that take no position, last flag on one of them
   task automatic test_ignored_bytes();
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_text(".");
      send_symbol(8'h00, 1'b1);
   endtask

   // full depth and full length in one string, then one position too many
   task automatic test_length_limit();
      steady = 1'b1;
      repeat (STACK_DEPTH) send_symbol(dbpm_pkg::SYM_OPEN_ROUND, 1'b0);
      repeat (STACK_DEPTH) send_symbol(dbpm_pkg::SYM_CLOSE_ROUND, 1'b0);
      send_symbol(dbpm_pkg::SYM_DOT, 1'b0);
      send_symbol(dbpm_pkg::SYM_CLOSE_SQUARE, 1'b0);
      send_symbol(dbpm_pkg::SYM_OPEN_ROUND, 1'b1);
      steady = 1'b0;
   endtask

   // one opener more than the square stack holds
   task automatic test_stack_overflow();
      repeat (STACK_DEPTH + 1) send_symbol(dbpm_pkg::SYM_OPEN_SQUARE, 1'b0);
      send_symbol(dbpm_pkg::SYM_CLOSE_SQUARE, 1'b0);
      send_symbol(dbpm_pkg::SYM_DOT, 1'b1);
   endtask

   // one random string; balanced ones may still carry stray bytes
   task automatic send_random_string(input bit balanced);
      logic [7:0] text[$];
      int         positions;
      int         round_open;
      int         square_open;
      int         remaining;
      int         pick;
      logic [7:0] sym;
      round_open  = 0;
      square_open = 0;
      positions   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
      for (int i = 0; i < positions; i++) begin
         remaining = positions - i;
         if ($urandom_range(0, 9) == 0)
            text.insert(text.size(),
                        $urandom_range(0, 3) == 0 ? 8'h26 : 8'($urandom_range(0, 255)));
         if (balanced) begin
            pick = $urandom_range(0, 4);
            if (round_open + square_open >= remaining)
               pick = (round_open > 0 && (square_open == 0 || $urandom_range(0, 1))) ? 3 : 4;
            else if ((pick == 1 || pick == 2) && round_open + square_open + 2 > remaining)
               pick = 0;
            else if ((pick == 3 && round_open == 0) || (pick == 4 && square_open == 0))
               pick = 0;
         end else begin
            pick = $urandom_range(0, 5);
         end
         case (pick)
            0:       sym = dbpm_pkg::SYM_DOT;
            1:       begin sym = dbpm_pkg::SYM_OPEN_ROUND;   round_open++;  end
            2:       begin sym = dbpm_pkg::SYM_OPEN_SQUARE;  square_open++; end
            3:       begin sym = dbpm_pkg::SYM_CLOSE_ROUND;  round_open--;  end
            4:       begin sym = dbpm_pkg::SYM_CLOSE_SQUARE; square_open--; end
            default: sym = 8'($urandom_range(0, 255));
         endcase
         text.insert(text.size(), sym);
      end
      foreach (text[i]) send_symbol(text[i], i == text.size() - 1);
   endtask

   // mostly balanced strings, some broken; periodic drains and a stretch without idling
   task automatic test_random_strings();
      int unsigned start_count;
      int unsigned strings;
      start_count = item_count;
      strings     = 0;
      while (item_count - start_count < RANDOM_ITEMS) begin
         send_random_string($urandom_range(0, 99) < 80);
         strings++;
         if (strings % 8 == 0) wait_for_responses();
         if (strings == 10) steady = 1'b1;
         if (strings == 14) steady = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_basic_pairs();
      test_error_codes();
      test_ignored_bytes();
      wait_for_responses();
      test_length_limit();
      test_stack_overflow();
      test_random_strings();
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_pairs.size() == 0)
         $display("dot_bracket_pair_matcher_core regression: pass");
      else
         $display("dot_bracket_pair_matcher_core regression: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dbpm_pkg.sv
rtl/dbpm_ram.sv
rtl/dbpm_stack.sv
rtl/dot_bracket_pair_matcher_core.sv
rtl/dbpm_checker.sv
tb/tb_dot_bracket_pair_matcher_core.sv
